// ===== hw/rtl/dhca_pkg.sv =====
// Package for the detector hit calibration and addback block.
// Holds sizes, codes, beat and command types shared by the RTL files (all but dhca_ram) and the testbench.
// Depends on nothing.
`timescale 1ns / 1ps

package dhca_pkg;

    // Array geometry.
    localparam int NUM_POSITIONS = 16;
    localparam int NUM_CRYSTALS  = 4;
    localparam int FRAC_BITS     = 8;
    localparam int SLOTS         = NUM_POSITIONS * NUM_CRYSTALS;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int E_DEPTH       = SLOTS * 3;
    localparam int T_DEPTH       = SLOTS * 2;
    localparam int EA_W          = $clog2(E_DEPTH);
    localparam int TA_W          = $clog2(T_DEPTH);

    // Shared multiply-accumulate unit.
    localparam int ACC_W = 116;
    localparam int MA_W  = 20;
    localparam int MB_W  = 32;
    localparam int P_W   = MA_W + MB_W;
    localparam int SH_W  = 7;

    // Result scaling: energy has 32 fraction bits, time has 24.
    localparam int E_SHIFT   = 32 - FRAC_BITS;
    localparam int T_SHIFT   = 24 - FRAC_BITS;
    localparam int E_LIM_BIT = 49;
    localparam int T_LIM_BIT = 40;
    localparam int E_OUT_W   = E_LIM_BIT - E_SHIFT;
    localparam int T_OUT_W   = T_LIM_BIT - T_SHIFT;
    localparam int S16K      = 16384;
    localparam int STAMP_SHIFT = 4;

    // Addback sums.
    localparam int SUM_E_W = 27;
    localparam int SUM_T_W = 26;
    localparam int CNT_W   = 3;
    localparam int DIV_CNT_W = $clog2(SUM_T_W + 1);

    // Load targets.
    localparam logic [2:0] WS_C0  = 3'd0;
    localparam logic [2:0] WS_C1  = 3'd1;
    localparam logic [2:0] WS_C2  = 3'd2;
    localparam logic [2:0] WS_D0  = 3'd3;
    localparam logic [2:0] WS_D1  = 3'd4;
    localparam logic [2:0] WS_RING = 3'd5;
    localparam logic [2:0] WS_EEN = 3'd6;
    localparam logic [2:0] WS_TEN = 3'd7;

    // Action, kind and error codes.
    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_HIT   = 1'b1;
    localparam logic KIND_CRYSTAL = 1'b0;
    localparam logic KIND_ADDBACK = 1'b1;
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LOW  = 2'd1;
    localparam logic [1:0] ERR_HIGH = 2'd2;

    typedef struct packed {
        logic               action;
        logic [4:0]         position;
        logic [1:0]         crystal;
        logic [2:0]         word_select;
        logic signed [31:0] value;
        logic [23:0]        cfd_time;
        logic [23:0]        stamp;
        logic               has_energy;
        logic               has_time;
        logic signed [7:0]  dither_e;
        logic signed [7:0]  dither_t;
        logic               last_in_event;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  out_position;
        logic [1:0]  out_crystal;
        logic [26:0] energy;
        logic [23:0] time_res;
        logic        energy_valid;
        logic        time_valid;
        logic        both_valid;
        logic [7:0]  ring;
        logic [2:0]  addback_count;
        logic [1:0]  energy_range_error;
        logic        last;
    } result_t;

    // One product term for the accumulator: acc += +-(a*b << sh).
    typedef struct packed {
        logic            vld;
        logic            clr;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
        logic [SH_W-1:0] sh;
        logic            neg;
    } mac_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FLUSH,
        ST_DIV,
        ST_EMIT_AB,
        ST_FETCH,
        ST_MAC,
        ST_UPD,
        ST_EMIT_CRY,
        ST_CLOSE
    } state_t;

endpackage

// ===== hw/rtl/dhca_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module dhca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dhca_mac.sv =====
// Shared multiply-accumulate unit: one 20x32 multiplier, a product register
// and a wide signed accumulator with shifted, optionally negated terms.
// Depends on dhca_pkg.
`timescale 1ns / 1ps

module dhca_mac
    import dhca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_cmd_t         cmd,
    output logic [ACC_W-1:0] acc
);

    logic [P_W-1:0]   prod_reg;
    logic [SH_W-1:0]  sh_reg;
    logic             neg_reg;
    logic             clr_reg;
    logic             vld_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] term;
    logic [ACC_W-1:0] base;

    // Multiply stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= cmd.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= P_W'(cmd.a) * P_W'(cmd.b);
        sh_reg   <= cmd.sh;
        neg_reg  <= cmd.neg;
        clr_reg  <= cmd.clr;
    end

    // Accumulate stage; a negated term is the inverted term plus a carry in.
    always_comb
    begin
        term     = ACC_W'(prod_reg) << sh_reg;
        base     = clr_reg ? '0 : acc_reg;
        acc_next = base + (neg_reg ? ~term : term) + ACC_W'(neg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hw/rtl/dhca_div.sv =====
// Restoring divider for the addback mean time, one quotient bit per cycle.
// Depends on dhca_pkg.
`timescale 1ns / 1ps

module dhca_div
    import dhca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_T_W-1:0] dividend,
    input  logic [CNT_W-1:0]   divisor,
    output logic               busy,
    output logic [SUM_T_W-1:0] quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [SUM_T_W-1:0]   dvd_reg;
    logic [SUM_T_W-1:0]   dvd_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [CNT_W-1:0]     dsr_reg;
    logic [CNT_W:0]       partial;
    logic                 fits;

    // One restoring step; quotient bits shift in where dividend bits leave.
    always_comb
    begin
        partial  = {rem_reg, dvd_reg[SUM_T_W-1]};
        fits     = partial >= {1'b0, dsr_reg};
        rem_next = fits ? CNT_W'(partial - {1'b0, dsr_reg}) : partial[CNT_W-1:0];
        dvd_next = {dvd_reg[SUM_T_W-2:0], fits};
        cnt_next = cnt_reg - DIV_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(SUM_T_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/detector_hit_calibrate_addback.sv =====
// Detector hit calibration with per-position addback, top level.
// Load beat: writes one table entry of a valid slot. Hit beat steps: flush check,
// 4 table reads, 18 steps of the shared 20x32 multiply-accumulate unit, update, result,
// close. Each addback adds a divide step and its own result beat.
// One item at a time; a stalled result holds the sequencer until that beat is taken.
// Reset clears control, enables, ring valid bits and the open group; coefficients undefined.
`timescale 1ns / 1ps

module detector_hit_calibrate_addback
    import dhca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Sequencer steps of the multiply-accumulate program.
    localparam logic [4:0] MS_SQ_LL  = 5'd0;
    localparam logic [4:0] MS_SQ_LH  = 5'd1;
    localparam logic [4:0] MS_SQ_HL  = 5'd2;
    localparam logic [4:0] MS_SQ_HH  = 5'd3;
    localparam logic [4:0] MS_C0     = 5'd5;
    localparam logic [4:0] MS_C1_L   = 5'd6;
    localparam logic [4:0] MS_C1_H   = 5'd7;
    localparam logic [4:0] MS_C2_0   = 5'd8;
    localparam logic [4:0] MS_C2_1   = 5'd9;
    localparam logic [4:0] MS_C2_2   = 5'd10;
    localparam logic [4:0] MS_C2_3   = 5'd11;
    localparam logic [4:0] MS_D0     = 5'd13;
    localparam logic [4:0] MS_D1_L   = 5'd14;
    localparam logic [4:0] MS_D1_H   = 5'd15;
    localparam logic [4:0] MS_T_CAP  = 5'd17;
    localparam logic [4:0] FS_LAST   = 5'd3;

    state_t state_reg;
    state_t state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    item_t item_reg;

    logic hit_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic load_en;

    // Tables.
    logic [SLOTS-1:0] eflag_vec_reg;
    logic [SLOTS-1:0] tflag_vec_reg;
    logic [SLOTS-1:0] ring_vld_reg;
    logic [31:0] e_rdata;
    logic [31:0] t_rdata;
    logic [7:0]  ring_rdata;

    // Fetched per-crystal values.
    logic [31:0] c0_reg, c1_reg, c2_reg, d0_reg, d1_reg;
    logic [7:0]  ring_reg;
    logic        eflag_reg;
    logic        tflag_reg;

    // Operands.
    logic [40:0] r_s;
    logic [40:0] r_abs;
    logic [39:0] m_val;
    logic [25:0] diff;
    logic [33:0] tr_s;
    logic [33:0] tr_abs;
    logic [39:0] tr_mag;
    logic [79:0] sq_reg;
    logic [31:0] c0_abs, c1_abs, c2_abs, d0_abs, d1_abs;

    mac_cmd_t mac_cmd;
    logic [ACC_W-1:0] mac_acc;

    // Per-hit results.
    logic               ev_reg;
    logic               tv_reg;
    logic [1:0]         err_reg;
    logic [E_OUT_W-1:0] e_out_reg;
    logic [T_OUT_W-1:0] t_out_reg;

    // Open addback group.
    logic [4:0]         open_reg;
    logic [SUM_E_W-1:0] sum_e_reg;
    logic [SUM_T_W-1:0] sum_t_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [E_OUT_W-1:0] best_e_reg;
    logic [1:0]         best_c_reg;
    logic               close_reg;
    logic               close_next;
    logic               grp_clr;
    logic               grp_upd;
    logic [SUM_E_W:0]   sum_e_add;
    logic [SUM_T_W:0]   sum_t_add;

    logic               div_start;
    logic               div_busy;
    logic [SUM_T_W-1:0] div_quo;

    result_t out_reg;
    result_t out_next;
    logic    out_vld_reg;
    logic    out_load;
    logic    out_free;
    result_t res_ab;
    result_t res_cry;

    // Slot lookup for the held item.
    always_comb
    begin
        hit_ok = (item_reg.position != 5'd0)
              && (32'(item_reg.position) <= NUM_POSITIONS)
              && (32'(item_reg.crystal) < NUM_CRYSTALS);
        slot_idx = hit_ok ? SLOT_W'((32'(item_reg.position) - 32'd1) * NUM_CRYSTALS
                                    + 32'(item_reg.crystal)) : '0;
        load_en = (state_reg == ST_LOAD) && hit_ok;
    end

    // Coefficient and ring memories.
    dhca_ram #(.WIDTH(32), .DEPTH(E_DEPTH)) u_e_ram (
        .clk   (clk),
        .we    (load_en && (item_reg.word_select <= WS_C2)),
        .waddr (EA_W'(32'(slot_idx) * 3 + 32'(item_reg.word_select))),
        .wdata (item_reg.value),
        .raddr (EA_W'(32'(slot_idx) * 3 + 32'(step_reg[1:0]))),
        .rdata (e_rdata)
    );

    dhca_ram #(.WIDTH(32), .DEPTH(T_DEPTH)) u_t_ram (
        .clk   (clk),
        .we    (load_en && ((item_reg.word_select == WS_D0)
                            || (item_reg.word_select == WS_D1))),
        .waddr (TA_W'(32'(slot_idx) * 2 + 32'(item_reg.word_select == WS_D1))),
        .wdata (item_reg.value),
        .raddr (TA_W'(32'(slot_idx) * 2 + 32'(step_reg[0]))),
        .rdata (t_rdata)
    );

    dhca_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_ring_ram (
        .clk   (clk),
        .we    (load_en && (item_reg.word_select == WS_RING)),
        .waddr (slot_idx),
        .wdata (item_reg.value[7:0]),
        .raddr (slot_idx),
        .rdata (ring_rdata)
    );

    // Enable bits and ring valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eflag_vec_reg <= '0;
            tflag_vec_reg <= '0;
            ring_vld_reg  <= '0;
        end
        else if (load_en)
        begin
            if (item_reg.word_select == WS_EEN)
            begin
                eflag_vec_reg[slot_idx] <= item_reg.value[0];
            end
            if (item_reg.word_select == WS_TEN)
            begin
                tflag_vec_reg[slot_idx] <= item_reg.value[0];
            end
            if (item_reg.word_select == WS_RING)
            begin
                ring_vld_reg[slot_idx] <= 1'b1;
            end
        end
    end

    // Dithered charge and time difference as magnitudes.
    always_comb
    begin
        r_s    = {item_reg.value[31], item_reg.value, 8'd0}
               + {{33{item_reg.dither_e[7]}}, item_reg.dither_e};
        r_abs  = r_s[40] ? (~r_s + 41'd1) : r_s;
        m_val  = r_abs[39:0];
        diff   = {2'd0, item_reg.cfd_time}
               - {2'd0, item_reg.stamp[23-STAMP_SHIFT:0], STAMP_SHIFT'(0)}
               + 26'(S16K);
        tr_s   = {diff, 8'd0} + {{26{item_reg.dither_t[7]}}, item_reg.dither_t};
        tr_abs = tr_s[33] ? (~tr_s + 34'd1) : tr_s;
        tr_mag = 40'(tr_abs);
        c0_abs = c0_reg[31] ? (~c0_reg + 32'd1) : c0_reg;
        c1_abs = c1_reg[31] ? (~c1_reg + 32'd1) : c1_reg;
        c2_abs = c2_reg[31] ? (~c2_reg + 32'd1) : c2_reg;
        d0_abs = d0_reg[31] ? (~d0_reg + 32'd1) : d0_reg;
        d1_abs = d1_reg[31] ? (~d1_reg + 32'd1) : d1_reg;
    end

    // Multiply-accumulate program: r*r, then c0 + c1*r + c2*r*r, then d0 + d1*tr.
    always_comb
    begin
        mac_cmd = '0;
        if (state_reg == ST_MAC)
        begin
            mac_cmd.vld = 1'b1;
            case (step_reg)
                MS_SQ_LL:
                begin
                    mac_cmd.clr = 1'b1;
                    mac_cmd.a   = m_val[19:0];
                    mac_cmd.b   = 32'(m_val[19:0]);
                end
                MS_SQ_LH:
                begin
                    mac_cmd.a  = m_val[19:0];
                    mac_cmd.b  = 32'(m_val[39:20]);
                    mac_cmd.sh = 7'd20;
                end
                MS_SQ_HL:
                begin
                    mac_cmd.a  = m_val[39:20];
                    mac_cmd.b  = 32'(m_val[19:0]);
                    mac_cmd.sh = 7'd20;
                end
                MS_SQ_HH:
                begin
                    mac_cmd.a  = m_val[39:20];
                    mac_cmd.b  = 32'(m_val[39:20]);
                    mac_cmd.sh = 7'd40;
                end
                MS_C0:
                begin
                    mac_cmd.clr = 1'b1;
                    mac_cmd.a   = 20'd1;
                    mac_cmd.b   = c0_abs;
                    mac_cmd.sh  = 7'd16;
                    mac_cmd.neg = c0_reg[31];
                end
                MS_C1_L:
                begin
                    mac_cmd.a   = m_val[19:0];
                    mac_cmd.b   = c1_abs;
                    mac_cmd.sh  = 7'd8;
                    mac_cmd.neg = c1_reg[31] ^ r_s[40];
                end
                MS_C1_H:
                begin
                    mac_cmd.a   = m_val[39:20];
                    mac_cmd.b   = c1_abs;
                    mac_cmd.sh  = 7'd28;
                    mac_cmd.neg = c1_reg[31] ^ r_s[40];
                end
                MS_C2_0:
                begin
                    mac_cmd.a   = sq_reg[19:0];
                    mac_cmd.b   = c2_abs;
                    mac_cmd.neg = c2_reg[31];
                end
                MS_C2_1:
                begin
                    mac_cmd.a   = sq_reg[39:20];
                    mac_cmd.b   = c2_abs;
                    mac_cmd.sh  = 7'd20;
                    mac_cmd.neg = c2_reg[31];
                end
                MS_C2_2:
                begin
                    mac_cmd.a   = sq_reg[59:40];
                    mac_cmd.b   = c2_abs;
                    mac_cmd.sh  = 7'd40;
                    mac_cmd.neg = c2_reg[31];
                end
                MS_C2_3:
                begin
                    mac_cmd.a   = sq_reg[79:60];
                    mac_cmd.b   = c2_abs;
                    mac_cmd.sh  = 7'd60;
                    mac_cmd.neg = c2_reg[31];
                end
                MS_D0:
                begin
                    mac_cmd.clr = 1'b1;
                    mac_cmd.a   = 20'd1;
                    mac_cmd.b   = d0_abs;
                    mac_cmd.sh  = 7'd8;
                    mac_cmd.neg = d0_reg[31];
                end
                MS_D1_L:
                begin
                    mac_cmd.a   = tr_mag[19:0];
                    mac_cmd.b   = d1_abs;
                    mac_cmd.neg = d1_reg[31] ^ tr_s[33];
                end
                MS_D1_H:
                begin
                    mac_cmd.a   = tr_mag[39:20];
                    mac_cmd.b   = d1_abs;
                    mac_cmd.sh  = 7'd20;
                    mac_cmd.neg = d1_reg[31] ^ tr_s[33];
                end
                default:
                begin
                    mac_cmd.vld = 1'b0;
                end
            endcase
        end
    end

    dhca_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (mac_acc)
    );

    dhca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_t_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Table fetch, square capture, result capture and item capture.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH)
        begin
            case (step_reg)
                5'd0:
                begin
                    eflag_reg <= eflag_vec_reg[slot_idx];
                    tflag_reg <= tflag_vec_reg[slot_idx];
                end
                5'd1:
                begin
                    c0_reg   <= e_rdata;
                    d0_reg   <= t_rdata;
                    ring_reg <= ring_vld_reg[slot_idx] ? ring_rdata : 8'd0;
                end
                5'd2:
                begin
                    c1_reg <= e_rdata;
                    d1_reg <= t_rdata;
                end
                default:
                begin
                    c2_reg <= e_rdata;
                end
            endcase
        end
        if ((state_reg == ST_MAC) && (step_reg == MS_C0))
        begin
            sq_reg <= mac_acc[79:0];
        end
        if ((state_reg == ST_MAC) && (step_reg == MS_D0))
        begin
            if (!(hit_ok && eflag_reg && item_reg.has_energy))
            begin
                ev_reg    <= 1'b0;
                err_reg   <= ERR_NONE;
                e_out_reg <= '0;
            end
            else if (mac_acc[ACC_W-1])
            begin
                ev_reg    <= 1'b0;
                err_reg   <= ERR_LOW;
                e_out_reg <= '0;
            end
            else if (|mac_acc[ACC_W-1:E_LIM_BIT])
            begin
                ev_reg    <= 1'b0;
                err_reg   <= ERR_HIGH;
                e_out_reg <= '0;
            end
            else
            begin
                ev_reg    <= 1'b1;
                err_reg   <= ERR_NONE;
                e_out_reg <= mac_acc[E_LIM_BIT-1:E_SHIFT];
            end
        end
        if ((state_reg == ST_MAC) && (step_reg == MS_T_CAP))
        begin
            if (hit_ok && tflag_reg && item_reg.has_time
                && !(|mac_acc[ACC_W-1:T_LIM_BIT]) && (|mac_acc[T_LIM_BIT-1:0]))
            begin
                tv_reg    <= 1'b1;
                t_out_reg <= mac_acc[T_LIM_BIT-1:T_SHIFT];
            end
            else
            begin
                tv_reg    <= 1'b0;
                t_out_reg <= '0;
            end
        end
        if ((state_reg == ST_IDLE) && item_valid)
        begin
            item_reg <= item;
        end
    end

    // Saturating group sums.
    always_comb
    begin
        sum_e_add = {1'b0, sum_e_reg} + (SUM_E_W + 1)'(e_out_reg);
        sum_t_add = {1'b0, sum_t_reg} + (SUM_T_W + 1)'(tv_reg ? t_out_reg : '0);
    end

    // Addback group state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= '0;
            sum_e_reg  <= '0;
            sum_t_reg  <= '0;
            cnt_reg    <= '0;
            best_e_reg <= '0;
            best_c_reg <= '0;
        end
        else if (grp_clr)
        begin
            open_reg   <= '0;
            sum_e_reg  <= '0;
            sum_t_reg  <= '0;
            cnt_reg    <= '0;
            best_e_reg <= '0;
            best_c_reg <= '0;
        end
        else if (grp_upd && hit_ok)
        begin
            open_reg <= item_reg.position;
            if (ev_reg)
            begin
                if ((cnt_reg == '0) || (e_out_reg > best_e_reg))
                begin
                    best_e_reg <= e_out_reg;
                    best_c_reg <= item_reg.crystal;
                end
                sum_e_reg <= sum_e_add[SUM_E_W] ? '1 : sum_e_add[SUM_E_W-1:0];
                sum_t_reg <= sum_t_add[SUM_T_W] ? '1 : sum_t_add[SUM_T_W-1:0];
                if (cnt_reg != '1)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Result beats.
    always_comb
    begin
        res_ab                    = '0;
        res_ab.kind               = KIND_ADDBACK;
        res_ab.out_position       = open_reg;
        res_ab.out_crystal        = best_c_reg;
        res_ab.energy             = sum_e_reg;
        res_ab.time_res           = div_quo[23:0];
        res_ab.energy_valid       = 1'b1;
        res_ab.addback_count      = cnt_reg;
        res_ab.last               = close_reg;

        res_cry                    = '0;
        res_cry.kind               = KIND_CRYSTAL;
        res_cry.out_position       = item_reg.position;
        res_cry.out_crystal        = item_reg.crystal;
        res_cry.energy             = 27'(e_out_reg);
        res_cry.time_res           = t_out_reg;
        res_cry.energy_valid       = ev_reg;
        res_cry.time_valid         = tv_reg;
        res_cry.both_valid         = ev_reg && tv_reg;
        res_cry.ring               = (hit_ok && (ev_reg || tv_reg)) ? ring_reg : 8'd0;
        res_cry.energy_range_error = err_reg;
        res_cry.last               = !(item_reg.last_in_event && (open_reg != '0)
                                       && (sum_e_reg != '0));

        out_free = !out_vld_reg || !result_stall;
    end

    // Sequencer: next state and control.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        close_next = close_reg;
        grp_clr    = 1'b0;
        grp_upd    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        out_next   = res_cry;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (item.action == ACTION_HIT) ? ST_FLUSH : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                step_next  = '0;
                state_next = ST_FETCH;
                if (hit_ok && (open_reg != '0) && (open_reg != item_reg.position))
                begin
                    if (sum_e_reg != '0)
                    begin
                        div_start  = 1'b1;
                        close_next = 1'b0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        grp_clr = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_EMIT_AB;
                end
            end
            ST_EMIT_AB:
            begin
                out_next = res_ab;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    grp_clr    = 1'b1;
                    step_next  = '0;
                    state_next = close_reg ? ST_IDLE : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == FS_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == MS_T_CAP)
                begin
                    step_next  = '0;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                grp_upd    = 1'b1;
                state_next = ST_EMIT_CRY;
            end
            ST_EMIT_CRY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                state_next = ST_IDLE;
                if (item_reg.last_in_event)
                begin
                    if ((open_reg != '0) && (sum_e_reg != '0))
                    begin
                        div_start  = 1'b1;
                        close_next = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        grp_clr = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            close_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            close_reg   <= close_next;
            out_vld_reg <= out_load || (out_vld_reg && result_stall);
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef ASSERT_OFF
    // An addback beat always carries a nonempty group.
    a_ab_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_ADDBACK))
        |-> ((result.energy != '0) && (result.addback_count != '0)))
        else $error("addback beat with empty group");

    // A crystal beat never has a range error together with valid energy.
    a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_CRYSTAL)
         && (result.energy_range_error != ERR_NONE))
        |-> !result.energy_valid)
        else $error("range error on valid energy");

    // An empty count means no summed energy.
    a_cnt_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (sum_e_reg == '0))
        else $error("energy sum without counted crystals");

    // The divider runs only while the sequencer waits for it.
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for detector_hit_calibrate_addback.
// Predicts crystal and addback beats in SystemVerilog and checks them against the DUT.
// Depends on dhca_pkg and the detector_hit_calibrate_addback RTL.
`timescale 1ns / 1ps

module testbench;
    import dhca_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 220;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    detector_hit_calibrate_addback u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Pending input beats and expected output beats.
    item_t   pending_items[$];
    result_t expected_results[$];

    // Predictor copy of the calibration tables.
    logic [31:0] e_coef[SLOTS][3];
    logic [31:0] t_coef[SLOTS][2];
    logic [7:0]  ring_tbl[SLOTS];
    logic        e_on[SLOTS];
    logic        t_on[SLOTS];

    // Predictor copy of the open addback group.
    logic [26:0] grp_esum;
    logic [25:0] grp_tsum;
    logic [2:0]  grp_count;
    logic [24:0] grp_best_e;
    logic [1:0]  grp_best_cr;
    logic [4:0]  grp_pos;

    // Stimulus generator bookkeeping of which table words are loaded.
    bit       gen_een[SLOTS];
    bit       gen_ten[SLOTS];
    bit [2:0] gen_ew[SLOTS];
    bit [1:0] gen_tw[SLOTS];

    int errors = 0;
    int items_in = 0;
    int hits_in = 0;
    int crystal_seen = 0;
    int addback_seen = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Emit the open group's addback if it holds energy, then close it.
    task automatic close_group(inout result_t beats[$]);
        result_t r;
        r = '0;
        if (grp_pos != 0 && grp_esum != 0)
        begin
            r.kind = KIND_ADDBACK;
            r.out_position = grp_pos;
            r.out_crystal = grp_best_cr;
            r.energy = grp_esum;
            r.time_res = (grp_count != 0) ? 24'(grp_tsum / grp_count) : '0;
            r.energy_valid = 1'b1;
            r.addback_count = grp_count;
            beats.push_back(r);
        end
        grp_esum = '0;
        grp_tsum = '0;
        grp_count = '0;
        grp_best_e = '0;
        grp_best_cr = '0;
        grp_pos = '0;
    endtask

    // Work out the result beats that one accepted item causes.
    task automatic calibrate_item(input item_t it);
        result_t beats[$];
        result_t r;
        bit in_range;
        int s;
        logic signed [127:0] rq, c0, c1, c2, acc, d0, d1, tr;
        logic [23:0] stamp_sc;
        longint diff;
        logic ev, tv;
        logic [24:0] e_out;
        logic [23:0] t_out;
        logic [1:0] err;
        longint sum;

        in_range = it.position >= 1 && it.position <= NUM_POSITIONS;
        s = in_range ? (int'(it.position) - 1) * NUM_CRYSTALS + int'(it.crystal) : 0;
        if (it.action == ACTION_LOAD)
        begin
            if (in_range)
            begin
                case (it.word_select)
                    WS_C0, WS_C1, WS_C2: e_coef[s][it.word_select] = it.value;
                    WS_D0, WS_D1: t_coef[s][it.word_select - WS_D0] = it.value;
                    WS_RING: ring_tbl[s] = it.value[7:0];
                    WS_EEN: e_on[s] = it.value[0];
                    default: t_on[s] = it.value[0];
                endcase
            end
            return;
        end

        // A hit for another position closes the open group first.
        if (in_range && grp_pos != 0 && grp_pos != it.position)
            close_group(beats);

        ev = 1'b0;
        tv = 1'b0;
        e_out = '0;
        t_out = '0;
        err = ERR_NONE;

        // Quadratic energy with 32 fraction bits.
        if (in_range && e_on[s] && it.has_energy)
        begin
            rq = $signed(it.value) * 256 + $signed(it.dither_e);
            c0 = $signed(e_coef[s][0]);
            c1 = $signed(e_coef[s][1]);
            c2 = $signed(e_coef[s][2]);
            acc = (c0 <<< 16) + ((c1 * rq) <<< 8) + c2 * rq * rq;
            if (acc < 0)
                err = ERR_LOW;
            else if (acc >= (128'sd1 <<< 49))
                err = ERR_HIGH;
            else
            begin
                ev = 1'b1;
                e_out = acc[48:24];
            end
        end

        // Linear time with 24 fraction bits.
        if (in_range && t_on[s] && it.has_time)
        begin
            stamp_sc = it.stamp << 4;
            diff = longint'(it.cfd_time) - longint'(stamp_sc) + S16K;
            tr = diff * 256 + $signed(it.dither_t);
            d0 = $signed(t_coef[s][0]);
            d1 = $signed(t_coef[s][1]);
            acc = (d0 <<< 8) + d1 * tr;
            if (acc > 0 && acc < (128'sd1 <<< 40))
            begin
                tv = 1'b1;
                t_out = acc[39:16];
            end
        end

        r = '0;
        r.kind = KIND_CRYSTAL;
        r.out_position = it.position;
        r.out_crystal = it.crystal;
        r.energy = 27'(e_out);
        r.time_res = t_out;
        r.energy_valid = ev;
        r.time_valid = tv;
        r.both_valid = ev && tv;
        r.ring = (in_range && (ev || tv)) ? ring_tbl[s] : '0;
        r.energy_range_error = err;
        beats.push_back(r);

        // Accumulate into the group, saturating each sum.
        if (in_range)
        begin
            grp_pos = it.position;
            if (ev)
            begin
                if (grp_count == 0 || e_out > grp_best_e)
                begin
                    grp_best_e = e_out;
                    grp_best_cr = it.crystal;
                end
                sum = longint'(grp_esum) + longint'(e_out);
                grp_esum = (sum > 64'h7ffffff) ? 27'h7ffffff : 27'(sum);
                sum = longint'(grp_tsum) + (tv ? longint'(t_out) : 0);
                grp_tsum = (sum > 64'h3ffffff) ? 26'h3ffffff : 26'(sum);
                if (grp_count < 7)
                    grp_count++;
            end
        end

        if (it.last_in_event)
            close_group(beats);

        beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i])
            expected_results.push_back(beats[i]);
    endtask

    // Gap length: mostly short, sometimes long, with busy stretches of no gaps.
    function automatic int pick_gap();
        int x;
        x = $urandom_range(0, 99);
        if ((($time / 4000) % 4) == 1)
            return 0;
        if (x < 50)
            return 0;
        if (x < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offer pending beats, hold a stalled beat, insert random gaps.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                calibrate_item(item);
                items_in++;
                if (item.action == ACTION_HIT)
                    hits_in++;
            end
            if (item_valid && item_stall)
            begin
                // Stalled beat stays as it is.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                send_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted beat and drive the output stall.
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected beat", 32'(result.energy), '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.kind == KIND_ADDBACK)
                        addback_seen++;
                    else
                        crystal_seen++;
                    if (result.kind !== want.kind)
                        report_mismatch("kind", result.kind, want.kind);
                    if (result.out_position !== want.out_position)
                        report_mismatch("out_position", result.out_position,
                                        want.out_position);
                    if (result.out_crystal !== want.out_crystal)
                        report_mismatch("out_crystal", result.out_crystal, want.out_crystal);
                    if (result.energy !== want.energy)
                        report_mismatch("energy", result.energy, want.energy);
                    if (result.time_res !== want.time_res)
                        report_mismatch("time_res", result.time_res, want.time_res);
                    if (result.energy_valid !== want.energy_valid)
                        report_mismatch("energy_valid", result.energy_valid,
                                        want.energy_valid);
                    if (result.time_valid !== want.time_valid)
                        report_mismatch("time_valid", result.time_valid, want.time_valid);
                    if (result.both_valid !== want.both_valid)
                        report_mismatch("both_valid", result.both_valid, want.both_valid);
                    if (result.ring !== want.ring)
                        report_mismatch("ring", result.ring, want.ring);
                    if (result.addback_count !== want.addback_count)
                        report_mismatch("addback_count", result.addback_count,
                                        want.addback_count);
                    if (result.energy_range_error !== want.energy_range_error)
                        report_mismatch("energy_range_error", result.energy_range_error,
                                        want.energy_range_error);
                    if (result.last !== want.last)
                        report_mismatch("last", result.last, want.last);
                end
            end
            // One long hold-off so that the block backs up into its input.
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && items_in >= 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Table word values: mostly sensible calibrations, sometimes anything.
    function automatic logic [31:0] pick_word(input logic [2:0] ws);
        bit wild;
        wild = $urandom_range(0, 9) == 0;
        case (ws)
            WS_C0: return wild ? $urandom() : 32'($signed($urandom_range(0, 131072)) - 65536);
            WS_C1: return wild ? $urandom() : 32'(65536 + $urandom_range(0, 16384) - 8192);
            WS_C2: return wild ? $urandom() : 32'($urandom_range(0, 8) - 4);
            WS_D0: return wild ? $urandom() : 32'($urandom_range(0, 2097152) - 1048576);
            WS_D1: return wild ? $urandom() : 32'(65536 + $urandom_range(0, 8192) - 4096);
            WS_RING: return $urandom();
            default: return (32'($urandom_range(0, 32'h7fffffff)) << 1) | 32'(wild ? 0 : 1);
        endcase
    endfunction

    task automatic add_load(input logic [4:0] pos, input logic [1:0] cr,
                            input logic [2:0] ws, input logic [31:0] val);
        item_t it;
        int s;
        it = '0;
        it.action = ACTION_LOAD;
        it.position = pos;
        it.crystal = cr;
        it.word_select = ws;
        it.value = val;
        it.cfd_time = 24'($urandom());
        it.stamp = 24'($urandom());
        it.last_in_event = 1'($urandom_range(0, 1));
        pending_items.push_back(it);
        if (pos >= 1 && pos <= NUM_POSITIONS)
        begin
            s = (int'(pos) - 1) * NUM_CRYSTALS + int'(cr);
            case (ws)
                WS_C0, WS_C1, WS_C2: gen_ew[s][ws] = 1'b1;
                WS_D0, WS_D1: gen_tw[s][ws - WS_D0] = 1'b1;
                WS_EEN: gen_een[s] = val[0];
                WS_TEN: gen_ten[s] = val[0];
                default: ;
            endcase
        end
    endtask

    task automatic setup_slot(input logic [4:0] pos, input logic [1:0] cr);
        for (int w = 0; w < 8; w++)
            add_load(pos, cr, 3'(w), pick_word(3'(w)));
    endtask

    // A hit never reads a coefficient that was not loaded.
    task automatic add_hit(input logic [4:0] pos, input logic [1:0] cr,
                           input logic [31:0] val, input bit fin, input bit near);
        item_t it;
        int s;
        it = '0;
        it.action = ACTION_HIT;
        it.position = pos;
        it.crystal = cr;
        it.word_select = 3'($urandom());
        it.value = val;
        it.stamp = 24'($urandom());
        if (near)
            it.cfd_time = 24'((it.stamp << 4) + $urandom_range(0, 40000) - S16K);
        else
            it.cfd_time = 24'($urandom());
        it.has_energy = $urandom_range(0, 7) != 0;
        it.has_time = $urandom_range(0, 7) != 0;
        it.dither_e = 8'($urandom());
        it.dither_t = 8'($urandom());
        it.last_in_event = fin;
        if (pos >= 1 && pos <= NUM_POSITIONS)
        begin
            s = (int'(pos) - 1) * NUM_CRYSTALS + int'(cr);
            if (gen_een[s] && gen_ew[s] != 3'b111)
                it.has_energy = 1'b0;
            if (gen_ten[s] && gen_tw[s] != 2'b11)
                it.has_time = 1'b0;
        end
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] pick_charge();
        int x;
        x = $urandom_range(0, 99);
        if (x < 85)
            return $urandom_range(0, 40000);
        if (x < 95)
            return 32'(-$signed($urandom_range(0, 1000)));
        return $urandom();
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        int npos, nhits, s;
        logic [4:0] pos;
        logic [1:0] cr;

        foreach (e_on[i])
        begin
            e_on[i] = 1'b0;
            t_on[i] = 1'b0;
            ring_tbl[i] = '0;
            e_coef[i] = '{default: '0};
            t_coef[i] = '{default: '0};
        end
        grp_esum = '0;
        grp_tsum = '0;
        grp_count = '0;
        grp_best_e = '0;
        grp_best_cr = '0;
        grp_pos = '0;

        // Directed: unity calibration on one crystal, out-of-range slots, extremes.
        add_load(5'd1, 2'd0, WS_C0, 32'd0);
        add_load(5'd1, 2'd0, WS_C1, 32'd65536);
        add_load(5'd1, 2'd0, WS_C2, 32'd0);
        add_load(5'd1, 2'd0, WS_D0, 32'd0);
        add_load(5'd1, 2'd0, WS_D1, 32'd65536);
        add_load(5'd1, 2'd0, WS_RING, 32'hffff_ffa5);
        add_load(5'd1, 2'd0, WS_EEN, 32'd1);
        add_load(5'd1, 2'd0, WS_TEN, 32'hffff_ffff);
        add_load(5'd0, 2'd1, WS_EEN, 32'd1);
        add_load(5'd17, 2'd3, WS_C0, 32'h8000_0000);
        add_load(5'd31, 2'd2, WS_TEN, 32'd1);
        add_hit(5'd1, 2'd0, 32'd1000, 1'b0, 1'b1);
        add_hit(5'd1, 2'd0, 32'h7fff_ffff, 1'b0, 1'b1);
        add_hit(5'd1, 2'd0, 32'h8000_0000, 1'b0, 1'b0);
        add_hit(5'd1, 2'd0, 32'd0, 1'b0, 1'b1);
        add_hit(5'd1, 2'd0, 32'd131071, 1'b1, 1'b1);
        add_hit(5'd1, 2'd0, 32'd500, 1'b0, 1'b1);
        add_hit(5'd0, 2'd0, 32'd500, 1'b1, 1'b1);
        add_hit(5'd1, 2'd0, 32'd700, 1'b0, 1'b1);
        add_hit(5'd2, 2'd3, 32'd700, 1'b0, 1'b1);
        add_hit(5'd16, 2'd3, 32'hffff_ffff, 1'b0, 1'b0);
        add_hit(5'd20, 2'd1, 32'd12, 1'b1, 1'b1);

        // Random: mostly well-formed events, some stray loads and noise hits.
        while (pending_items.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: add_load(5'($urandom()), 2'($urandom()), 3'($urandom()),
                            pick_word(3'($urandom())));
                1: add_hit(5'($urandom()), 2'($urandom()), $urandom(),
                           1'($urandom_range(0, 1)), 1'b0);
                default:
                begin
                    npos = $urandom_range(1, 3);
                    for (int p = 0; p < npos && pending_items.size() < ITEM_TARGET; p++)
                    begin
                        pos = 5'($urandom_range(1, NUM_POSITIONS));
                        nhits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
                                                            : $urandom_range(1, 4);
                        for (int h = 0; h < nhits && pending_items.size() < ITEM_TARGET;
                             h++)
                        begin
                            cr = 2'($urandom());
                            s = (int'(pos) - 1) * NUM_CRYSTALS + int'(cr);
                            if (gen_ew[s] != 3'b111 && $urandom_range(0, 3) != 0)
                                setup_slot(pos, cr);
                            add_hit(pos, cr, pick_charge(),
                                    p == npos - 1 && h == nhits - 1,
                                    $urandom_range(0, 4) != 0);
                        end
                    end
                end
            endcase
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Run covered %0d items (%0d hits), giving %0d crystal and %0d addback beats.",
                 items_in, hits_in, crystal_seen, addback_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dhca_pkg.sv
hw/rtl/dhca_ram.sv
hw/rtl/dhca_mac.sv
hw/rtl/dhca_div.sv
hw/rtl/detector_hit_calibrate_addback.sv
tb/testbench.sv
